FILE: sv/mrk_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package mrk_pkg;

  localparam int NDIM   = 4;
  localparam int CW     = 12;
  localparam int EW     = 13;
  localparam int IW     = 48;
  localparam int LEN_W  = 52;
  localparam int QSTEPS = 13;
  localparam int SH_W   = LEN_W + QSTEPS;

  localparam logic [1:0] MODE_LIN  = 2'd0;
  localparam logic [1:0] MODE_SPLIT = 2'd1;
  localparam logic [1:0] MODE_VLIN = 2'd2;
  localparam logic [1:0] MODE_PACK = 2'd3;

  localparam logic [2:0] CFG_DIM_COUNT = 3'd0;
  localparam logic [2:0] CFG_EXTENT_A  = 3'd1;
  localparam logic [2:0] CFG_EXTENT_B  = 3'd2;
  localparam logic [2:0] CFG_EXTENT_C  = 3'd3;
  localparam logic [2:0] CFG_EXTENT_D  = 3'd4;

  typedef struct packed {
    logic [1:0]                  mode;
    logic [NDIM-1:0]             view;
    logic [NDIM-1:0][CW-1:0]     coord;
    logic [LEN_W-1:0]            rem;
    logic [LEN_W-1:0]            acc;
    logic [NDIM-1:0][LEN_W-1:0]  len;
    logic [IW-1:0]               idx;
    logic [NDIM-1:0][EW-1:0]     quo;
    logic                        fault;
  } mrk_tok_t;

  // One restoring step: try len[k] << b against the running remainder.
  function automatic mrk_tok_t div_step(input mrk_tok_t t, input logic [1:0] k,
                                        input logic [3:0] b);
    mrk_tok_t        r;
    logic [SH_W-1:0] sh;
    r  = t;
    sh = SH_W'(t.len[k]) << b;
    if (SH_W'(t.rem) >= sh) begin
      r.rem       = t.rem - sh[LEN_W-1:0];
      r.quo[k][b] = 1'b1;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

FILE: sv/mrk_in_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface mrk_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic [11:0] coord_a;
  logic [11:0] coord_b;
  logic [11:0] coord_c;
  logic [11:0] coord_d;
  logic [47:0] flat_index;
  logic [3:0]  view_mask;
  modport source (output valid, mode, coord_a, coord_b, coord_c, coord_d, flat_index,
                  view_mask, input ready);
  modport sink (input valid, mode, coord_a, coord_b, coord_c, coord_d, flat_index,
                view_mask, output ready);
endinterface
`default_nettype wire

FILE: sv/mrk_out_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface mrk_out_if;
  logic        valid;
  logic        ready;
  logic [47:0] index_out;
  logic [11:0] out_a;
  logic [11:0] out_b;
  logic [11:0] out_c;
  logic [11:0] out_d;
  logic [2:0]  packed_count;
  logic        range_fault;
  modport source (output valid, index_out, out_a, out_b, out_c, out_d, packed_count,
                  range_fault, input ready);
  modport sink (input valid, index_out, out_a, out_b, out_c, out_d, packed_count,
                range_fault, output ready);
endinterface
`default_nettype wire

FILE: sv/mrk_cfg_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface mrk_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [12:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

FILE: sv/mixed_radix_key_index_converter.sv
`timescale 1ns / 1ps
`default_nettype none
// Path from an accepted input beat to its result beat: 4 extent-product cells,
// then 4 division cells of 13 steps each, then 1 output register.
// Throughput: one item per cycle; the whole cell chain holds while a result
// waits on the output register, so input ready follows output ready.
// Reset (rst_n low, synchronous): dim_count = 1, all extents = 1, pipeline empty.
module mixed_radix_key_index_converter #(
  parameter int MAX_DIMS   = 4,
  parameter int COORD_BITS = 12
) (
  input  wire logic clk,
  input  wire logic rst_n,
  mrk_in_if.sink    in_bus,
  mrk_out_if.source out_bus,
  mrk_cfg_if.sink   cfg_bus
);

  localparam int          ND   = mrk_pkg::NDIM;
  localparam logic [2:0]  CAP  = (MAX_DIMS > ND) ? 3'(ND) : 3'(MAX_DIMS);
  localparam logic [16:0] ETOP = 17'(1) << COORD_BITS;

  logic [2:0]              dim_count_r;
  logic [ND-1:0][12:0]     ext_r;
  logic [2:0]              n_used;
  logic [ND-1:0][12:0]     eff;
  logic [ND-1:0][12:0]     lenx;
  logic [ND-1:0]           used;
  logic                    en;

  assign cfg_bus.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dim_count_r <= 3'd1;
      ext_r       <= {ND{13'd1}};
    end else if (cfg_bus.valid) begin
      unique case (cfg_bus.index)
        mrk_pkg::CFG_DIM_COUNT: dim_count_r <= cfg_bus.data[2:0];
        mrk_pkg::CFG_EXTENT_A:  ext_r[0] <= cfg_bus.data;
        mrk_pkg::CFG_EXTENT_B:  ext_r[1] <= cfg_bus.data;
        mrk_pkg::CFG_EXTENT_C:  ext_r[2] <= cfg_bus.data;
        mrk_pkg::CFG_EXTENT_D:  ext_r[3] <= cfg_bus.data;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (dim_count_r == 3'd0)   n_used = 3'd1;
    else if (dim_count_r > CAP) n_used = CAP;
    else                        n_used = dim_count_r;
    for (int i = 0; i < ND; i++) begin
      used[i] = 3'(i) < n_used;
      if (ext_r[i] == 13'd0)                  eff[i] = 13'd1;
      else if (17'(ext_r[i]) > ETOP)          eff[i] = ETOP[12:0];
      else                                    eff[i] = ext_r[i];
      lenx[i] = used[i] ? eff[i] : 13'd1;
    end
  end

  assign en           = !out_bus.valid || out_bus.ready;
  assign in_bus.ready = en;

  mrk_pkg::mrk_tok_t p_tok [ND+1];
  logic              p_v   [ND+1];
  mrk_pkg::mrk_tok_t d_tok [ND+1];
  logic              d_v   [ND+1];

  always_comb begin
    p_tok[0]       = '0;
    p_tok[0].mode  = in_bus.mode;
    p_tok[0].view  = in_bus.view_mask;
    p_tok[0].coord = {in_bus.coord_d, in_bus.coord_c, in_bus.coord_b, in_bus.coord_a};
    p_tok[0].rem   = mrk_pkg::LEN_W'(in_bus.flat_index);
    p_tok[0].acc   = mrk_pkg::LEN_W'(1);
  end
  assign p_v[0] = in_bus.valid;

  // product cells walk from the least significant dimension up
  for (genvar j = 0; j < ND; j++) begin : g_len
    mrk_len_cell #(.K(ND - 1 - j)) u_len (
      .clk, .rst_n, .en,
      .v_in(p_v[j]), .tok_in(p_tok[j]),
      .ext(lenx[ND-1-j]), .used(used[ND-1-j]),
      .v_out(p_v[j+1]), .tok_out(p_tok[j+1])
    );
  end

  assign d_tok[0] = p_tok[ND];
  assign d_v[0]   = p_v[ND];

  for (genvar k = 0; k < ND; k++) begin : g_div
    mrk_div_cell #(.K(k)) u_div (
      .clk, .rst_n, .en,
      .v_in(d_v[k]), .tok_in(d_tok[k]),
      .ext(lenx[k]), .used(used[k]),
      .v_out(d_v[k+1]), .tok_out(d_tok[k+1])
    );
  end

  mrk_pkg::mrk_tok_t   t;
  logic [47:0]         idx_nxt;
  logic [ND-1:0][11:0] slot_nxt;
  logic [2:0]          cnt_nxt;
  logic                out_valid_r;
  logic [47:0]         idx_r;
  logic [ND-1:0][11:0] slot_r;
  logic [2:0]          cnt_r;
  logic                fault_r;

  assign t = d_tok[ND];

  always_comb begin
    idx_nxt  = '0;
    slot_nxt = '0;
    cnt_nxt  = '0;
    unique case (t.mode)
      mrk_pkg::MODE_LIN, mrk_pkg::MODE_VLIN: idx_nxt = t.idx;
      mrk_pkg::MODE_SPLIT: begin
        if (!t.fault)
          for (int i = 0; i < ND; i++) slot_nxt[i] = t.quo[i][11:0];
      end
      mrk_pkg::MODE_PACK: begin
        for (int i = 0; i < ND; i++) begin
          if (used[i] && t.view[i]) begin
            slot_nxt[cnt_nxt[1:0]] = t.coord[i];
            cnt_nxt = cnt_nxt + 3'd1;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= d_v[ND];
    end
    if (en && d_v[ND]) begin
      idx_r   <= idx_nxt;
      slot_r  <= slot_nxt;
      cnt_r   <= cnt_nxt;
      fault_r <= t.fault;
    end
  end

  assign out_bus.valid        = out_valid_r;
  assign out_bus.index_out    = idx_r;
  assign out_bus.out_a        = slot_r[0];
  assign out_bus.out_b        = slot_r[1];
  assign out_bus.out_c        = slot_r[2];
  assign out_bus.out_d        = slot_r[3];
  assign out_bus.packed_count = cnt_r;
  assign out_bus.range_fault  = fault_r;

  a_pack_no_index: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && cnt_r != 3'd0 |-> idx_r == 48'd0)
    else $error("packed result carries an index");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> cnt_r <= 3'd4)
    else $error("packed count beyond dimension count");

  a_index_no_slots: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && idx_r != 48'd0 |-> slot_r == '0 && cnt_r == 3'd0)
    else $error("index result carries coordinates");

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid_r)
    else $error("result valid after reset");

endmodule
`default_nettype wire

FILE: sv/mrk_len_cell.sv
`timescale 1ns / 1ps
`default_nettype none
module mrk_len_cell #(
  parameter int K = 0
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              en,
  input  wire logic              v_in,
  input  wire mrk_pkg::mrk_tok_t tok_in,
  input  wire logic [12:0]       ext,
  input  wire logic              used,
  output logic                   v_out,
  output mrk_pkg::mrk_tok_t      tok_out
);

  logic              v_r;
  mrk_pkg::mrk_tok_t tok_r, tok_nxt;
  logic              sel;

  always_comb begin
    tok_nxt = tok_in;
    sel = used && (tok_in.mode == mrk_pkg::MODE_LIN ||
                   ((tok_in.mode == mrk_pkg::MODE_VLIN || tok_in.mode == mrk_pkg::MODE_PACK)
                    && tok_in.view[K]));
    if (sel && ({1'b0, tok_in.coord[K]} >= ext)) tok_nxt.fault = 1'b1;
    tok_nxt.len[K] = tok_in.acc;
    // extents of unused dimensions arrive as one
    tok_nxt.acc = mrk_pkg::LEN_W'(tok_in.acc * mrk_pkg::LEN_W'(ext));
    if (K == 0 && tok_in.mode == mrk_pkg::MODE_SPLIT && tok_in.rem >= tok_nxt.acc)
      tok_nxt.fault = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= v_in;
    end
    if (en) tok_r <= tok_nxt;
  end

  assign v_out   = v_r;
  assign tok_out = tok_r;

endmodule
`default_nettype wire

FILE: sv/mrk_div_cell.sv
`timescale 1ns / 1ps
`default_nettype none
module mrk_div_cell #(
  parameter int K = 0
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              en,
  input  wire logic              v_in,
  input  wire mrk_pkg::mrk_tok_t tok_in,
  input  wire logic [12:0]       ext,
  input  wire logic              used,
  output logic                   v_out,
  output mrk_pkg::mrk_tok_t      tok_out
);

  localparam int QS = mrk_pkg::QSTEPS;

  logic              v_r   [QS];
  mrk_pkg::mrk_tok_t st_r  [QS];
  mrk_pkg::mrk_tok_t head;
  logic              sel;

  // Horner step of the linear index rides in the first stage
  always_comb begin
    head = tok_in;
    sel  = used && (tok_in.mode == mrk_pkg::MODE_LIN ||
                    (tok_in.mode == mrk_pkg::MODE_VLIN && tok_in.view[K]));
    if (sel)
      head.idx = mrk_pkg::IW'(tok_in.idx * mrk_pkg::IW'(ext)) + mrk_pkg::IW'(tok_in.coord[K]);
  end

  for (genvar s = 0; s < QS; s++) begin : g_step
    mrk_pkg::mrk_tok_t src;
    logic              src_v;
    if (s == 0) begin : g_first
      assign src   = head;
      assign src_v = v_in;
    end else begin : g_next
      assign src   = st_r[s-1];
      assign src_v = v_r[s-1];
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[s] <= 1'b0;
      end else if (en) begin
        v_r[s] <= src_v;
      end
      if (en) st_r[s] <= mrk_pkg::div_step(src, 2'(K), 4'(QS - 1 - s));
    end
  end

  assign v_out   = v_r[QS-1];
  assign tok_out = st_r[QS-1];

endmodule
`default_nettype wire
